// ===== rtl/core/llbm_pkg.sv =====
// Shared types and constants for the lockable latch bank mapper.
`default_nettype none

package llbm_pkg;

   localparam int unsigned PRG_BANK_BITS_DEFAULT = 6;
   localparam int unsigned PRG_BANK_OUT_BITS = 6;
   localparam int unsigned CHR_BANK_BITS = 7;
   localparam int unsigned CHR_UPPER_BITS = 5;
   localparam int unsigned CHR_LOW_BITS = 2;
   localparam int unsigned LATCH_ADDR_BITS = 9;
   localparam int unsigned DIP_BITS = 4;
   localparam int unsigned SCRATCH_CELLS = 4;
   localparam int unsigned SCRATCH_IDX_BITS = $clog2(SCRATCH_CELLS);
   localparam int unsigned SCRATCH_BITS = 4;

   localparam int unsigned DIP_EN_BIT = 6;
   localparam int unsigned MODE_BIT = 7;
   localparam int unsigned LOCK_BIT = 8;
   localparam int unsigned MIRROR_DATA_BIT = 7;

   localparam logic [15:0] SCRATCH_BASE = 16'h5800;
   localparam logic [15:0] SCRATCH_LAST = 16'h5FFF;
   localparam logic [15:0] ROM_BASE = 16'h8000;

   typedef enum logic [1:0] {
      OP_READ       = 2'd0,
      OP_WRITE      = 2'd1,
      OP_SOFT_RESET = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef struct packed {
      logic scratch_wr;
      logic latch_wr;
      logic soft_reset;
   } llbm_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/llbm_if.sv =====
// Request and response channel interfaces of the bank mapper.
`default_nettype none

interface llbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] cpu_address;
   logic [7:0]  write_value;

   modport source (output valid, output operation, output cpu_address, output write_value,
                   input ready);
   modport sink (input valid, input operation, input cpu_address, input write_value,
                 output ready);
endinterface

interface llbm_rsp_if;
   logic        valid;
   logic        ready;
   logic        scratch_hit;
   logic [3:0]  scratch_value;
   logic        rom_read;
   logic [15:0] rom_address;
   logic [5:0]  prg_bank_low;
   logic [5:0]  prg_bank_high;
   logic [6:0]  chr_bank;
   logic        mirroring;

   modport source (output valid, output scratch_hit, output scratch_value, output rom_read,
                   output rom_address, output prg_bank_low, output prg_bank_high,
                   output chr_bank, output mirroring, input ready);
   modport sink (input valid, input scratch_hit, input scratch_value, input rom_read,
                 input rom_address, input prg_bank_low, input prg_bank_high,
                 input chr_bank, input mirroring, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/llbm_regs.sv =====
// Mapper state registers: latch, lock, banks, mirroring, DIP counter and scratch cells.
`default_nettype none

module llbm_regs #(
   parameter int unsigned PRG_BANK_BITS = llbm_pkg::PRG_BANK_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire llbm_pkg::llbm_cmd_type   cmd,
   input  wire logic [15:0]              cpu_address,
   input  wire logic [7:0]               write_value,
   output logic [PRG_BANK_BITS-1:0]      bank_low,
   output logic [PRG_BANK_BITS-1:0]      bank_high,
   output logic [llbm_pkg::CHR_BANK_BITS-1:0] chr_bank,
   output logic                          mirroring,
   output logic                          dip_enable,
   output logic [llbm_pkg::DIP_BITS-1:0] dip_count,
   output logic [llbm_pkg::SCRATCH_BITS-1:0] scratch_rd
);
   import llbm_pkg::*;

   logic                        dip_en_ff, dip_en_in;
   logic [CHR_LOW_BITS-1:0]     chr_low_ff, chr_low_in;
   logic                        lock_ff, lock_in;
   logic [CHR_UPPER_BITS-1:0]   chr_upper_ff, chr_upper_in;
   logic [DIP_BITS-1:0]         dip_ff, dip_in;
   logic [PRG_BANK_BITS-1:0]    bank_low_ff, bank_low_in;
   logic [PRG_BANK_BITS-1:0]    bank_high_ff, bank_high_in;
   logic                        mirror_ff, mirror_in;
   logic [SCRATCH_BITS-1:0]     scratch_ff [SCRATCH_CELLS];

   logic [LATCH_ADDR_BITS-1:0]  new_addr;
   logic [7:0]                  new_data;
   logic [LATCH_ADDR_BITS-1:0]  low_full;
   logic [LATCH_ADDR_BITS-1:0]  high_full;
   logic                        apply;
   logic [SCRATCH_IDX_BITS-1:0] scratch_idx;

   assign scratch_idx = cpu_address[SCRATCH_IDX_BITS-1:0];

   // A soft reset loads a cleared latch and applies it as an unlocked write.
   always_comb begin
      new_addr = cmd.soft_reset ? '0 : cpu_address[LATCH_ADDR_BITS-1:0];
      new_data = cmd.soft_reset ? '0 : write_value;
      apply = cmd.soft_reset || (cmd.latch_wr && !lock_ff);

      low_full = new_addr[MODE_BIT] ? new_addr : {new_addr[LATCH_ADDR_BITS-1:1], 1'b0};
      high_full = new_addr[MODE_BIT] ? new_addr : {new_addr[LATCH_ADDR_BITS-1:1], 1'b1};

      dip_en_in = dip_en_ff;
      chr_low_in = chr_low_ff;
      if (cmd.latch_wr || cmd.soft_reset) begin
         dip_en_in = new_addr[DIP_EN_BIT];
         chr_low_in = new_data[CHR_LOW_BITS-1:0];
      end

      lock_in = lock_ff;
      chr_upper_in = chr_upper_ff;
      bank_low_in = bank_low_ff;
      bank_high_in = bank_high_ff;
      mirror_in = mirror_ff;
      if (apply) begin
         lock_in = new_addr[LOCK_BIT];
         chr_upper_in = new_data[CHR_LOW_BITS +: CHR_UPPER_BITS];
         bank_low_in = low_full[PRG_BANK_BITS-1:0];
         bank_high_in = high_full[PRG_BANK_BITS-1:0];
         mirror_in = ~new_data[MIRROR_DATA_BIT];
      end

      dip_in = cmd.soft_reset ? dip_ff + DIP_BITS'(1) : dip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dip_en_ff <= 1'b0;
         chr_low_ff <= '0;
         lock_ff <= 1'b0;
         chr_upper_ff <= '0;
         dip_ff <= '0;
         bank_low_ff <= '0;
         bank_high_ff <= PRG_BANK_BITS'(1);
         mirror_ff <= 1'b1;
      end else begin
         dip_en_ff <= dip_en_in;
         chr_low_ff <= chr_low_in;
         lock_ff <= lock_in;
         chr_upper_ff <= chr_upper_in;
         dip_ff <= dip_in;
         bank_low_ff <= bank_low_in;
         bank_high_ff <= bank_high_in;
         mirror_ff <= mirror_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SCRATCH_CELLS; i++) begin
            scratch_ff[i] <= '0;
         end
      end else if (cmd.scratch_wr) begin
         scratch_ff[scratch_idx] <= write_value[SCRATCH_BITS-1:0];
      end
   end

   assign bank_low = bank_low_ff;
   assign bank_high = bank_high_ff;
   assign chr_bank = {chr_upper_ff, chr_low_ff};
   assign mirroring = mirror_ff;
   assign dip_enable = dip_en_ff;
   assign dip_count = dip_ff;
   assign scratch_rd = scratch_ff[scratch_idx];

endmodule

`default_nettype wire

// ===== rtl/core/lockable_latch_bank_mapper.sv =====
// Top level of the lockable latch bank mapper: access decode, state and result register.
// A result is registered: it is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; a new item is taken while the result register
// is empty or its item is being taken in the same cycle.
// Reset (synchronous): lock clear, banks 0 and 1, vertical mirroring, scratch cells,
// latch and DIP counter zero, result register empty.
`default_nettype none

module lockable_latch_bank_mapper #(
   parameter int unsigned PRG_BANK_BITS = llbm_pkg::PRG_BANK_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   llbm_req_if.sink   req_bus,
   llbm_rsp_if.source rsp_bus
);
   import llbm_pkg::*;

   logic                     accept;
   logic                     scratch_range;
   logic                     rom_range;
   llbm_cmd_type             cmd;
   op_type                   op;

   logic [PRG_BANK_BITS-1:0] bank_low;
   logic [PRG_BANK_BITS-1:0] bank_high;
   logic [CHR_BANK_BITS-1:0] chr_bank;
   logic                     mirroring;
   logic                     dip_enable;
   logic [DIP_BITS-1:0]      dip_count;
   logic [SCRATCH_BITS-1:0]  scratch_rd;
   logic [8:0]               bank_low_wide;
   logic [8:0]               bank_high_wide;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     scratch_hit_ff, scratch_hit_in;
   logic [SCRATCH_BITS-1:0]  scratch_value_ff, scratch_value_in;
   logic                     rom_read_ff, rom_read_in;
   logic [15:0]              rom_address_ff, rom_address_in;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      op = op_type'(req_bus.operation);
      scratch_range = (req_bus.cpu_address >= SCRATCH_BASE)
                      && (req_bus.cpu_address <= SCRATCH_LAST);
      rom_range = req_bus.cpu_address >= ROM_BASE;

      cmd = '0;
      scratch_hit_in = 1'b0;
      scratch_value_in = '0;
      rom_read_in = 1'b0;
      rom_address_in = '0;
      case (op)
         OP_READ: begin
            if (scratch_range) begin
               scratch_hit_in = 1'b1;
               scratch_value_in = scratch_rd;
            end else if (rom_range) begin
               rom_read_in = 1'b1;
               rom_address_in = dip_enable
                                ? {req_bus.cpu_address[15:DIP_BITS], dip_count}
                                : req_bus.cpu_address;
            end
         end
         OP_WRITE: begin
            cmd.scratch_wr = accept && scratch_range;
            cmd.latch_wr = accept && !scratch_range && rom_range;
         end
         OP_SOFT_RESET: begin
            cmd.soft_reset = accept;
         end
         default: begin
         end
      endcase

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);
   end

   llbm_regs #(
      .PRG_BANK_BITS(PRG_BANK_BITS)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cpu_address (req_bus.cpu_address),
      .write_value (req_bus.write_value),
      .bank_low    (bank_low),
      .bank_high   (bank_high),
      .chr_bank    (chr_bank),
      .mirroring   (mirroring),
      .dip_enable  (dip_enable),
      .dip_count   (dip_count),
      .scratch_rd  (scratch_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         scratch_hit_ff <= scratch_hit_in;
         scratch_value_ff <= scratch_value_in;
         rom_read_ff <= rom_read_in;
         rom_address_ff <= rom_address_in;
      end
   end

   // The state only moves when an item is accepted, and that happens only as the
   // pending result leaves, so the live state is the state after the shown item.
   assign bank_low_wide = 9'(bank_low);
   assign bank_high_wide = 9'(bank_high);

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.scratch_hit = scratch_hit_ff;
   assign rsp_bus.scratch_value = scratch_value_ff;
   assign rsp_bus.rom_read = rom_read_ff;
   assign rsp_bus.rom_address = rom_address_ff;
   assign rsp_bus.prg_bank_low = bank_low_wide[PRG_BANK_OUT_BITS-1:0];
   assign rsp_bus.prg_bank_high = bank_high_wide[PRG_BANK_OUT_BITS-1:0];
   assign rsp_bus.chr_bank = chr_bank;
   assign rsp_bus.mirroring = mirroring;

   a_hit_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(scratch_hit_ff && rom_read_ff))
      else $error("Result flags both a scratch hit and a ROM read.");

   a_rom_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rom_read_ff) |-> (rom_address_ff == 16'h0000))
      else $error("ROM address is nonzero on a result that is not a ROM read.");

   a_soft_reset_banks: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_SOFT_RESET) |=>
         (bank_low == '0 && bank_high == PRG_BANK_BITS'(1) && mirroring
          && chr_bank == '0 && !dip_enable))
      else $error("Soft reset did not restore the default banks.");

   a_soft_reset_dip: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_SOFT_RESET) |=> (dip_count == $past(dip_count) + DIP_BITS'(1)))
      else $error("Soft reset did not advance the DIP counter.");

   a_scratch_read: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_READ && !scratch_range) |=> (scratch_value_ff == '0))
      else $error("Scratch value is nonzero on a read outside the scratch range.");

endmodule

`default_nettype wire
